>>> hw/rtl/lmcr_pkg.sv
// Shared types, constants and a helper function for the LED matrix chain refresh block.
// Used by led_matrix_chain_refresh; has no dependencies of its own.
`default_nettype none
package lmcr_pkg;

  // Number of driver chips on the chain (1 to 4).
  localparam int DEVICES = 4;

  localparam int ROWS     = 8;
  localparam int ROW_W    = 3;
  localparam int DEV_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int FRAME_W  = 64;
  localparam int CFG_IDX_W = 3;

  // The frame store is addressed as {row, device}.
  localparam int ST_AW    = ROW_W + DEV_W;
  localparam int ST_DEPTH = ROWS * (1 << DEV_W);

  // Request function codes.
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_REFRESH = 2'd1;
  localparam logic [1:0] FUNC_INIT    = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST      = 3'd4;

  // Driver register addresses used by the set-up frames.
  localparam logic [BYTE_W-1:0] REG_DECODE    = 8'h09;
  localparam logic [BYTE_W-1:0] REG_INTENSITY = 8'h0A;
  localparam logic [BYTE_W-1:0] REG_SCAN      = 8'h0B;
  localparam logic [BYTE_W-1:0] REG_SHUTDOWN  = 8'h0C;
  localparam logic [BYTE_W-1:0] REG_TEST      = 8'h0F;

  // Frame sequence: five set-up frames, then one frame per row.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SETUP0 = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ROW0   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd12;

  typedef logic [FRAME_W-1:0] frame_t;

  // Frame that carries the same register address and byte to every device.
  function automatic frame_t frame_same(input logic [BYTE_W-1:0] addr,
                                        input logic [BYTE_W-1:0] val);
    frame_t acc;
    acc = '0;
    for (int d = 0; d < DEVICES; d++) begin
      acc = {acc[FRAME_W-WORD_W-1:0], addr, val};
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lmcr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used for the frame store of led_matrix_chain_refresh.
`default_nettype none
module lmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/led_matrix_chain_refresh.sv
// Frame store and frame sequencer for a daisy chain of 8x8 LED matrix drivers.
// Depends on lmcr_pkg and the lmcr_ram frame store memory.
//
// A write request stores one byte in the frame store. A refresh
// sends eight frames, row 1 to row 8, each holding one 16-bit word per device with
// device 0 in the top word. Every device byte is a separate read of the frame store's
// single read port, issued in ST_RD and captured in ST_CAP. An init sends five
// set-up frames and eight zero frames; a clear sends the eight zero frames. Only one
// request is worked on at a time. The frame store reads as all zeros after reset;
// there is no clearing pass.
`default_nettype none
module led_matrix_chain_refresh
  import lmcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_func,
  input  wire logic [ROW_W-1:0]     in_row,
  input  wire logic [DEV_W-1:0]     in_device,
  input  wire logic [BYTE_W-1:0]    in_pixels,
  input  wire logic                 in_invert,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FRAME_W-1:0]        out_frame_bits,
  output logic                      out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [DEV_W-1:0] LAST_DEV = DEV_W'(DEVICES - 1);

  logic [1:0]          state_r, state_nxt;
  logic                cmd_ref_r, cmd_ref_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  frame_t              acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  frame_t              out_frame_r, out_frame_nxt;
  logic                out_last_r, out_last_nxt;

  logic [BYTE_W-1:0]   decode_r;
  logic [3:0]          intensity_r;
  logic [2:0]          scan_r;
  logic                run_r;
  logic                test_r;

  logic [ST_DEPTH-1:0] vld_r;
  logic                rd_vld_r;

  logic                in_acc;
  logic                wr_en;
  logic [ST_AW-1:0]    wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic [ST_AW-1:0]    rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic [ROW_W-1:0]    row_cur;
  logic [BYTE_W-1:0]   addr_cur;
  logic [BYTE_W-1:0]   val_cur;
  logic [BYTE_W-1:0]   byte_rd;
  frame_t              frame_cur;
  logic                out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign wr_en   = in_acc && (in_func == FUNC_WRITE) && (int'(in_device) < DEVICES);
  assign wr_addr = {in_row, in_device};
  assign wr_data = in_invert ? ~in_pixels : in_pixels;

  assign row_cur = ROW_W'(step_r - STEP_ROW0);
  assign rd_addr = {row_cur, dev_r};

  lmcr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ST_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // An entry never written since reset reads as zero.
  assign byte_rd = rd_vld_r ? rd_data : '0;

  always_comb begin
    case (step_r)
      4'd0:    addr_cur = REG_DECODE;
      4'd1:    addr_cur = REG_INTENSITY;
      4'd2:    addr_cur = REG_SCAN;
      4'd3:    addr_cur = REG_SHUTDOWN;
      4'd4:    addr_cur = REG_TEST;
      default: addr_cur = BYTE_W'(row_cur) + 8'd1;
    endcase
    case (step_r)
      4'd0:    val_cur = decode_r;
      4'd1:    val_cur = {4'd0, intensity_r};
      4'd2:    val_cur = {5'd0, scan_r};
      4'd3:    val_cur = {7'd0, run_r};
      4'd4:    val_cur = {7'd0, test_r};
      default: val_cur = '0;
    endcase
  end

  assign frame_cur = cmd_ref_r ? acc_r : frame_same(addr_cur, val_cur);

  always_comb begin
    state_nxt     = state_r;
    cmd_ref_nxt   = cmd_ref_r;
    step_nxt      = step_r;
    dev_nxt       = dev_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_frame_nxt = out_frame_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func != FUNC_WRITE)) begin
          cmd_ref_nxt = (in_func == FUNC_REFRESH);
          step_nxt    = (in_func == FUNC_INIT) ? STEP_SETUP0 : STEP_ROW0;
          dev_nxt     = '0;
          acc_nxt     = '0;
          state_nxt   = (in_func == FUNC_REFRESH) ? ST_RD : ST_EMIT;
        end
      end
      ST_RD: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        acc_nxt = {acc_r[FRAME_W-WORD_W-1:0], addr_cur, byte_rd};
        if (dev_r == LAST_DEV) begin
          state_nxt = ST_EMIT;
        end else begin
          dev_nxt   = dev_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = frame_cur;
          out_last_nxt  = (step_r == STEP_LAST);
          if (step_r == STEP_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
            if (cmd_ref_r) begin
              dev_nxt   = '0;
              acc_nxt   = '0;
              state_nxt = ST_RD;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_ref_r   <= 1'b0;
      step_r      <= '0;
      dev_r       <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      decode_r    <= 8'd0;
      intensity_r <= 4'd8;
      scan_r      <= 3'd7;
      run_r       <= 1'b1;
      test_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_ref_r   <= cmd_ref_nxt;
      step_r      <= step_nxt;
      dev_r       <= dev_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECODE:    decode_r    <= cfg_data;
          CFG_INTENSITY: intensity_r <= cfg_data[3:0];
          CFG_SCAN:      scan_r      <= cfg_data[2:0];
          CFG_RUN:       run_r       <= cfg_data[0];
          CFG_TEST:      test_r      <= cfg_data[0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_frame_r <= out_frame_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_bits = out_frame_r;
  assign out_last       = out_last_r;

  // The store is only read while a refresh is running.
  a_rd_only_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> cmd_ref_r)
    else $error("frame store read outside a refresh");

  // Every captured byte follows a read issued in the cycle before.
  a_cap_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAP) |-> ($past(state_r) == ST_RD) && $stable(rd_addr))
    else $error("byte captured without a matching read");

  // The frame step never runs past the last row.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (step_r <= STEP_LAST))
    else $error("frame step out of range");

  // A last frame is only loaded on the way back to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && step_r == STEP_LAST) |=>
      (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("last frame without return to idle");

endmodule
`default_nettype wire
